### rtl/gdd_pkg.sv
// gdd_pkg: constants, types and calendar functions for the gregorian date difference unit
// depends on nothing; used by gregorian_date_difference_unit and its testbench
package gdd_pkg;

   localparam int DayW      = 5;
   localparam int MonthW    = 4;
   localparam int YearW     = 14;
   localparam int DayNumW   = 22;
   localparam int DiffW     = 23;
   localparam int YearLimit = 9999;

   // floor(x / 100) for x < 2**YearW, as a multiply by a scaled reciprocal
   localparam int Recip100W     = 27;
   localparam int Recip100      = 5243;
   localparam int Recip100Shift = 19;
   localparam int Quot100W      = 8;

   typedef logic [DayNumW-1:0] day_num_type;
   typedef logic signed [DiffW-1:0] diff_type;

   typedef struct packed {
      logic [DayW-1:0]   day;
      logic [MonthW-1:0] month;
      logic [YearW-1:0]  year;
   } date_type;

   localparam logic [4:0] MonthLen [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

   localparam logic [8:0] DaysBeforeMonth [12] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334};

   function automatic logic [Quot100W-1:0] div100(logic [YearW-1:0] x);
      logic [Recip100W-1:0] prod;
      prod = Recip100W'(x) * Recip100W'(Recip100);
      return prod[Recip100Shift +: Quot100W];
   endfunction

   // 4/100/400 rule
   function automatic logic leap_year(logic [YearW-1:0] y);
      logic [Quot100W-1:0] q;
      logic                by100;
      q     = div100(y);
      by100 = (y == YearW'(q) * YearW'(100));
      return ((y[1:0] == 2'b00) && !by100) || (by100 && (q[1:0] == 2'b00));
   endfunction

   function automatic logic date_valid(date_type dt);
      logic [4:0] len;
      logic [3:0] mi;
      if ((dt.month < 4'd1) || (dt.month > 4'd12) || (dt.year > YearW'(YearLimit))) begin
         return 1'b0;
      end
      mi  = dt.month - 4'd1;
      len = MonthLen[mi];
      if ((dt.month == 4'd2) && leap_year(dt.year)) begin
         len = 5'd29;
      end
      return (dt.day != '0) && (dt.day <= len);
   endfunction

   // days since year 0 jan 1, plus one; month must be in range
   function automatic day_num_type day_number(date_type dt);
      logic [YearW-1:0]   y3;
      logic [YearW-1:0]   y99;
      logic [YearW-1:0]   y399;
      logic [11:0]        leaps;
      logic [3:0]         mi;
      logic [DayNumW-1:0] base;
      mi    = dt.month - 4'd1;
      y3    = dt.year + YearW'(3);
      y99   = dt.year + YearW'(99);
      y399  = dt.year + YearW'(399);
      leaps = 12'(y3 >> 2) - 12'(div100(y99)) + 12'(div100(y399 >> 2));
      base  = DayNumW'(dt.year) * DayNumW'(365);
      return base + DayNumW'(leaps) + DayNumW'(DaysBeforeMonth[mi])
             + DayNumW'((dt.month > 4'd2) && leap_year(dt.year)) + DayNumW'(dt.day);
   endfunction

endpackage

### rtl/gregorian_date_difference_unit.sv
// gregorian_date_difference_unit: signed day count between two gregorian dates
// depends on gdd_pkg (calendar functions, widths, month tables)

// The unit takes a word holding two proleptic gregorian dates (year 0 to 9999) and
// returns one word with the signed number of days from the first date to the second,
// negative when the first date is later. With csr_wr_data written as 1 the magnitude
// grows by one, so equal dates give +1. A month outside 1..12, a day of 0 or past the
// month end, or a year above 9999 in either date sets rsp_date_error with a zero
// difference. The datapath is a three-register pipeline: an input register, a register
// holding both day numbers (each a constant-reciprocal division and table sum), and the
// result register after the subtract and end-day adjust. rsp_valid rises when a word
// reaches the result register, and a new word is taken every cycle as long as the
// result side does not stall; a stall backs up through the stages, each stage still
// filling while the one after it holds. The end-day mode is sampled at the last stage;
// it is to be written only while the unit is empty, which the unit does not enforce.
module gregorian_date_difference_unit
   import gdd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // configuration
   input  logic                    csr_wr_en,
   input  logic                    csr_wr_data,
   // request words
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [DayW-1:0]         req_first_day,
   input  logic [MonthW-1:0]       req_first_month,
   input  logic [YearW-1:0]        req_first_year,
   input  logic [DayW-1:0]         req_second_day,
   input  logic [MonthW-1:0]       req_second_month,
   input  logic [YearW-1:0]        req_second_year,
   // response words
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [DiffW-1:0] rsp_day_difference,
   output logic                    rsp_date_error
);

   // end-day mode register
   logic count_end_day_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_end_day_ff <= 1'b0;
      end else if (csr_wr_en) begin
         count_end_day_ff <= csr_wr_data;
      end
   end

   // stage valids and advance chain, from the output back to the input
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_load, s2_load, s3_load;

   assign s3_load   = !s3_valid_ff || !rsp_stall;
   assign s2_load   = !s2_valid_ff || s3_load;
   assign s1_load   = !s1_valid_ff || s2_load;
   assign req_stall = !s1_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_load) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_load) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   // stage 1: input register
   date_type first_ff, second_ff;

   always_ff @(posedge clock) begin
      if (s1_load && req_valid) begin
         first_ff  <= '{day: req_first_day,  month: req_first_month,  year: req_first_year};
         second_ff <= '{day: req_second_day, month: req_second_month, year: req_second_year};
      end
   end

   // stage 2: day numbers and validity of both dates
   day_num_type num1_ff, num2_ff, num1_in, num2_in;
   logic        bad_ff, bad_in;

   always_comb begin
      bad_in  = !(date_valid(first_ff) && date_valid(second_ff));
      num1_in = day_number(first_ff);
      num2_in = day_number(second_ff);
   end

   always_ff @(posedge clock) begin
      if (s2_load && s1_valid_ff) begin
         num1_ff <= num1_in;
         num2_ff <= num2_in;
         bad_ff  <= bad_in;
      end
   end

   // stage 3: subtract, end-day adjust, force zero on error
   diff_type diff_ff, diff_in, raw_diff;
   logic     err_ff;

   always_comb begin
      raw_diff = diff_type'({1'b0, num2_ff}) - diff_type'({1'b0, num1_ff});
      diff_in  = raw_diff;
      if (count_end_day_ff) begin
         // non-negative (including equal dates) grows up, negative grows down
         diff_in = raw_diff[DiffW-1] ? raw_diff - diff_type'(1) : raw_diff + diff_type'(1);
      end
      if (bad_ff) begin
         diff_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_load && s2_valid_ff) begin
         diff_ff <= diff_in;
         err_ff  <= bad_ff;
      end
   end

   assign rsp_valid          = s3_valid_ff;
   assign rsp_day_difference = diff_ff;
   assign rsp_date_error     = err_ff;

   // an error word never carries a nonzero difference
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_date_error) |-> (rsp_day_difference == '0))
      else $error("error word with nonzero difference");

   // back-pressure reaches the input only when every stage is full
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s2_valid_ff && s3_valid_ff && rsp_stall))
      else $error("input stalled with a free stage");

   // reset empties the pipeline
   assert property (@(posedge clock) reset |=> (!rsp_valid && !s1_valid_ff && !s2_valid_ff))
      else $error("pipeline not empty after reset");

endmodule

### tb/tb_gregorian_date_difference_unit.sv
// tb_gregorian_date_difference_unit: self-checking bench for the date difference unit
// depends on gdd_pkg for field widths and the date struct, and on the unit's rtl
module tb_gregorian_date_difference_unit
   import gdd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // idle cycles with no word moved on either side before the run is declared hung
   localparam int StallLimit = 3000;
   // receiver hold-off length, long enough to fill the pipeline and back up the input
   localparam int HoldCycles = 80;
   // settle time after the last word, before the verdict
   localparam int DrainCycles = 12;
   // percent of cycles in which a side idles
   localparam int IdlePct = 11;

   localparam int DaysInMonth [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   typedef struct {
      diff_type days;
      logic     err;
   } day_span_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_wr_en = 1'b0;
   logic                    csr_wr_data = 1'b0;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [DayW-1:0]         req_first_day = '0;
   logic [MonthW-1:0]       req_first_month = '0;
   logic [YearW-1:0]        req_first_year = '0;
   logic [DayW-1:0]         req_second_day = '0;
   logic [MonthW-1:0]       req_second_month = '0;
   logic [YearW-1:0]        req_second_year = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [DiffW-1:0] rsp_day_difference;
   logic                    rsp_date_error;

   // bench-side copy of the end-day register
   bit           end_day_mode = 1'b0;
   // no random idling on either side while set
   bit           quiet = 1'b0;
   int           holds_asked = 0;
   int           holds_granted = 0;
   int           hold_left = 0;
   int           error_count = 0;
   int           idle_cycles = 0;
   day_span_type pending_spans[$];

   gregorian_date_difference_unit DUT (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_first_day      (req_first_day),
      .req_first_month    (req_first_month),
      .req_first_year     (req_first_year),
      .req_second_day     (req_second_day),
      .req_second_month   (req_second_month),
      .req_second_year    (req_second_year),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_day_difference (rsp_day_difference),
      .rsp_date_error     (rsp_date_error)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------- calendar predictor

   function automatic bit is_leap(int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int month_days(int m, int y);
      if ((m == 2) && is_leap(y)) begin
         return 29;
      end
      return DaysInMonth[m-1];
   endfunction

   // checks a date and gives its serial day (days since year 0 jan 1, plus one)
   function automatic bit serial_day(date_type dt, output int num);
      int y;
      int m;
      int d;
      int leaps;
      int ahead;
      y   = dt.year;
      m   = dt.month;
      d   = dt.day;
      num = 0;
      if ((m < 1) || (m > 12) || (y > YearLimit)) begin
         return 1'b0;
      end
      if ((d < 1) || (d > month_days(m, y))) begin
         return 1'b0;
      end
      // leap days in the years strictly before y
      leaps = (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
      ahead = 0;
      for (int i = 1; i < m; i++) begin
         ahead += month_days(i, y);
      end
      num = 365 * y + leaps + ahead + d;
      return 1'b1;
   endfunction

   function automatic day_span_type predict_span(date_type a, date_type b);
      day_span_type r;
      int           na;
      int           nb;
      int           diff;
      bit           ok_a;
      bit           ok_b;
      ok_a = serial_day(a, na);
      ok_b = serial_day(b, nb);
      if (!(ok_a && ok_b)) begin
         r.days = '0;
         r.err  = 1'b1;
         return r;
      end
      diff = nb - na;
      // end-day mode widens the span away from zero, equal dates give +1
      if (end_day_mode) begin
         diff = (diff >= 0) ? diff + 1 : diff - 1;
      end
      r.days = DiffW'(diff);
      r.err  = 1'b0;
      return r;
   endfunction

   function automatic date_type mk_date(int y, int m, int d);
      date_type dt;
      dt.day   = DayW'(d);
      dt.month = MonthW'(m);
      dt.year  = YearW'(y);
      return dt;
   endfunction

   // mostly valid dates, weighted toward century years and the top of the range,
   // with some raw bit patterns and some one-past-month-end days
   function automatic date_type random_date();
      int pick;
      int y;
      int m;
      pick = $urandom_range(99);
      if (pick < 10) begin
         return mk_date($urandom_range(16383), $urandom_range(15), $urandom_range(31));
      end
      if (pick < 20) begin
         y = 100 * $urandom_range(99) + $urandom_range(4);
      end else if (pick < 35) begin
         y = $urandom_range(9999, 8192);
      end else begin
         y = $urandom_range(9999);
      end
      m = $urandom_range(12, 1);
      if (pick < 15) begin
         return mk_date(y, m, month_days(m, y) + 1);
      end
      return mk_date(y, m, $urandom_range(month_days(m, y), 1));
   endfunction

   // second date: often in the same year or identical, so small and zero spans show up
   function automatic date_type random_partner(date_type a);
      int       pick;
      int       m;
      date_type b;
      pick = $urandom_range(99);
      if ((pick < 8) || (a.year > YearLimit)) begin
         return (pick < 4) ? a : random_date();
      end
      if (pick < 35) begin
         m = $urandom_range(12, 1);
         b = mk_date(a.year, m, $urandom_range(month_days(m, a.year), 1));
         return b;
      end
      return random_date();
   endfunction

   // ---------------------------------------------------------------- drivers

   // offers one word and holds it until the unit takes it
   task automatic send_dates(date_type a, date_type b);
      if (!quiet) begin
         while ($urandom_range(99) < IdlePct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid        <= 1'b1;
      req_first_day    <= a.day;
      req_first_month  <= a.month;
      req_first_year   <= a.year;
      req_second_day   <= b.day;
      req_second_month <= b.month;
      req_second_year  <= b.year;
      do begin
         @(posedge clock);
      end while (req_stall);
      pending_spans.push_back(predict_span(a, b));
   endtask

   task automatic send_ymd(int y1, int m1, int d1, int y2, int m2, int d2);
      send_dates(mk_date(y1, m1, d1), mk_date(y2, m2, d2));
   endtask

   // drops valid and waits until every expected word has come back
   task automatic wait_idle();
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
      end while (pending_spans.size() != 0);
   endtask

   task automatic set_end_day(bit v);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      end_day_mode = v;
   endtask

   task automatic send_random(int n);
      date_type a;
      for (int i = 0; i < n; i++) begin
         a = random_date();
         send_dates(a, random_partner(a));
      end
   endtask

   // ---------------------------------------------------------------- tests

   // field extremes, leap rules, sign and every kind of invalid date
   task automatic test_directed_dates();
      send_ymd(2000, 1, 1, 2000, 1, 1);       // equal dates
      send_ymd(0, 1, 1, 9999, 12, 31);        // widest positive span
      send_ymd(9999, 12, 31, 0, 1, 1);        // widest negative span
      send_ymd(2000, 2, 29, 2000, 3, 1);      // leap by 400
      send_ymd(1900, 2, 28, 1900, 3, 1);      // century, not leap
      send_ymd(0, 2, 29, 0, 3, 1);            // year 0 is leap
      send_ymd(2024, 2, 29, 2023, 2, 28);
      send_ymd(1900, 2, 29, 2000, 1, 1);      // feb 29 in a non-leap century
      send_ymd(2000, 1, 1, 2023, 2, 29);      // bad second date
      send_ymd(2000, 0, 1, 2000, 1, 1);       // month zero
      send_ymd(2000, 13, 1, 2000, 1, 1);
      send_ymd(2000, 1, 1, 2000, 15, 31);     // all month bits set
      send_ymd(2000, 1, 0, 2000, 1, 1);       // day zero
      send_ymd(2000, 4, 31, 2000, 5, 1);      // past month end
      send_ymd(2000, 1, 31, 2000, 12, 31);
      send_ymd(10000, 1, 1, 2000, 1, 1);      // year just over the limit
      send_ymd(2000, 1, 1, 16383, 12, 31);    // all year bits set
      send_ymd(9999, 12, 31, 9999, 12, 31);
      send_ymd(1899, 12, 31, 1900, 1, 1);
      send_ymd(2000, 12, 31, 2001, 1, 1);
      send_ymd(1600, 2, 29, 1700, 2, 28);
      send_ymd(0, 1, 1, 0, 1, 1);
   endtask

   // end-day mode on: equal dates, both signs, both extremes, an invalid date
   task automatic test_end_day_directed();
      set_end_day(1'b1);
      send_ymd(2000, 1, 1, 2000, 1, 1);
      send_ymd(0, 1, 1, 9999, 12, 31);
      send_ymd(9999, 12, 31, 0, 1, 1);
      send_ymd(2000, 1, 1, 2000, 1, 2);
      send_ymd(2000, 1, 2, 2000, 1, 1);
      send_ymd(2000, 0, 1, 2000, 1, 1);
   endtask

   task automatic test_random_mixed(bit mode, int n);
      set_end_day(mode);
      send_random(n);
   endtask

   // a long stretch with no idling on either side
   task automatic test_back_to_back(int n);
      set_end_day(1'b0);
      quiet = 1'b1;
      send_random(n);
      quiet = 1'b0;
   endtask

   // receiver holds off while words keep coming, so the pipeline fills and stalls the input
   task automatic test_output_backpressure(int n);
      set_end_day(1'b1);
      quiet = 1'b1;
      holds_asked++;
      send_random(n);
      quiet = 1'b0;
   endtask

   // sender stops until everything has drained, then starts again
   task automatic test_sender_pause(int n);
      send_random(n);
      wait_idle();
      send_random(n);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_dates();
      test_end_day_directed();
      test_random_mixed(1'b1, 300);
      test_back_to_back(300);
      test_output_backpressure(40);
      test_sender_pause(30);
      test_random_mixed(1'b0, 400);
      wait_idle();
      // let any stray word show up before the verdict
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // ---------------------------------------------------------------- receiver side

   // random stall, or a counted hold-off when a test asks for one
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (holds_granted != holds_asked) begin
         holds_granted++;
         hold_left = HoldCycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < IdlePct);
      end
   end

   // each accepted result word against the oldest expectation
   always @(posedge clock) begin
      day_span_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_spans.size() == 0) begin
            $display("%0t: result word with none expected: diff %0d err %b",
                     $time, rsp_day_difference, rsp_date_error);
            error_count++;
         end else begin
            want = pending_spans.pop_front();
            if (rsp_day_difference !== want.days) begin
               $display("%0t: day_difference expected %0d actual %0d",
                        $time, want.days, rsp_day_difference);
               error_count++;
            end
            if (rsp_date_error !== want.err) begin
               $display("%0t: date_error expected %b actual %b",
                        $time, want.err, rsp_date_error);
               error_count++;
            end
         end
      end
   end

   // hang detector: cycles in a row with no word moved on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $display("%0t: no word moved for %0d cycles", $time, StallLimit);
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
